FILE: design/kvcs_pkg.sv
`timescale 1ns / 1ps

package kvcs_pkg;

  localparam int unsigned Q16_ONE   = 65536;
  localparam int unsigned VEL_MAX   = 16777216;
  localparam int unsigned KNOB_DIV  = 4095;
  localparam int unsigned KNOB_RND  = 2047;
  localparam int unsigned DIV_STEPS = 17;
  localparam int unsigned DIV_CW    = $clog2(DIV_STEPS);

  // configuration register indexes
  localparam logic [2:0] REG_CENTER   = 3'd0;
  localparam logic [2:0] REG_DEADBAND = 3'd1;
  localparam logic [2:0] REG_ALPHA    = 3'd2;
  localparam logic [2:0] REG_VMAX     = 3'd3;
  localparam logic [2:0] REG_THRESH   = 3'd4;
  localparam logic [2:0] REG_STEP     = 3'd5;
  localparam logic [2:0] REG_INVERT   = 3'd6;

  // knob classification
  localparam logic [1:0] KIND_ZERO = 2'd0;
  localparam logic [1:0] KIND_POS  = 2'd1;
  localparam logic [1:0] KIND_NEG  = 2'd2;

  typedef struct packed {
    logic [16:0] center;
    logic [16:0] deadband;
    logic [16:0] alpha;
    logic [24:0] vmax;
    logic [24:0] thresh;
    logic [24:0] step;
    logic        invert;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [16:0] num;
    logic [16:0] den;
  } q_entry_t;

endpackage

FILE: design/kvcs_front.sv
`timescale 1ns / 1ps

module kvcs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  kvcs_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [11:0]       sample,
  input  logic              q_full,
  output logic              q_push,
  output kvcs_pkg::q_entry_t q_entry
);

  logic        norm_vld_r;
  logic [16:0] norm_r;
  logic [16:0] norm_nxt;

  logic [27:0] x;
  logic [28:0] y;
  logic [16:0] q_est;
  logic [28:0] rem;

  // x / 4095 estimated as (x + x/4096) / 4096, which is at most one short
  always_comb begin
    x        = {sample, 16'b0} + 28'(kvcs_pkg::KNOB_RND);
    y        = {1'b0, x} + {13'b0, x[27:12]};
    q_est    = y[28:12];
    rem      = {1'b0, x} - 29'(q_est * 29'(kvcs_pkg::KNOB_DIV));
    norm_nxt = (rem >= 29'(kvcs_pkg::KNOB_DIV)) ? q_est + 17'd1 : q_est;
  end

  assign in_ready = !norm_vld_r;
  assign q_push   = norm_vld_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      norm_vld_r <= 1'b1;
    end else if (q_push) begin
      norm_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      norm_r <= norm_nxt;
    end
  end

  logic [17:0]        pos;
  logic signed [17:0] neg;

  always_comb begin
    pos = {1'b0, cfg.center} + {1'b0, cfg.deadband};
    neg = $signed({1'b0, cfg.center}) - $signed({1'b0, cfg.deadband});
    q_entry.kind = kvcs_pkg::KIND_ZERO;
    q_entry.num  = '0;
    q_entry.den  = 17'd1;
    if ({1'b0, norm_r} > pos) begin
      q_entry.kind = kvcs_pkg::KIND_POS;
      q_entry.num  = norm_r - pos[16:0];
      q_entry.den  = 17'(18'(kvcs_pkg::Q16_ONE) - pos);
    end else if ($signed({1'b0, norm_r}) < neg) begin
      q_entry.kind = kvcs_pkg::KIND_NEG;
      q_entry.num  = neg[16:0] - norm_r;
      q_entry.den  = neg[16:0];
    end
  end

endmodule

FILE: design/kvcs_queue.sv
`timescale 1ns / 1ps

module kvcs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  kvcs_pkg::q_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output kvcs_pkg::q_entry_t head
);

  kvcs_pkg::q_entry_t slot_r [2];
  logic               wr_ptr_r;
  logic               rd_ptr_r;
  logic [1:0]         count_r;

  assign full  = (count_r == 2'd2);
  assign valid = (count_r != 2'd0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: design/kvcs_div.sv
`timescale 1ns / 1ps

// Restoring divider: quot = floor(num * 65536 / den), num <= den.
module kvcs_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [16:0] num,
  input  logic [16:0] den,
  output logic        done,
  output logic [16:0] quot
);

  localparam logic [kvcs_pkg::DIV_CW-1:0] LAST = kvcs_pkg::DIV_CW'(kvcs_pkg::DIV_STEPS - 1);

  logic                       busy_r;
  logic                       done_r;
  logic [kvcs_pkg::DIV_CW-1:0] cnt_r;
  logic [16:0]                rem_r;
  logic [16:0]                den_r;
  logic [16:0]                quot_r;

  logic [17:0] trial;
  logic        ge;
  logic [16:0] rem_nxt;

  // first step compares the plain numerator, later steps shift in a zero
  always_comb begin
    trial   = (cnt_r == '0) ? {1'b0, rem_r} : {rem_r, 1'b0};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? 17'(trial - {1'b0, den_r}) : trial[16:0];
  end

  assign done = done_r;
  assign quot = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[15:0], ge};
    end
  end

endmodule

FILE: design/kvcs_back.sv
`timescale 1ns / 1ps

module kvcs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  kvcs_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  kvcs_pkg::q_entry_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [25:0]        out_velocity,
  output logic               out_enable,
  output logic [17:0]        out_filtered
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_CMD  = 3'd2;
  localparam logic [2:0] ST_MUL1 = 3'd3;
  localparam logic [2:0] ST_FILT = 3'd4;
  localparam logic [2:0] ST_MUL2 = 3'd5;
  localparam logic [2:0] ST_VEL  = 3'd6;
  localparam logic [2:0] ST_SLEW = 3'd7;

  logic [2:0]         state_r, state_nxt;
  logic [1:0]         kind_r;
  logic signed [17:0] cmd_r;
  logic signed [17:0] s_r;
  logic               seeded_r;
  logic signed [36:0] prod1_r;
  logic signed [43:0] prod2_r;
  logic signed [25:0] vel_r;
  logic signed [25:0] tgt_r;
  logic               out_valid_r;
  logic [25:0]        out_vel_r;
  logic               out_en_r;
  logic [17:0]        out_filt_r;

  logic               div_start;
  logic               div_done;
  logic [16:0]        div_quot;

  kvcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (q_head.num),
    .den   (q_head.den),
    .done  (div_done),
    .quot  (div_quot)
  );

  logic               out_free;
  logic               negate;
  logic [17:0]        cmd_mag;
  logic signed [17:0] cmd_nxt;
  logic signed [18:0] diff;
  logic signed [36:0] prod1_nxt;
  logic signed [36:0] rnd1;
  logic signed [20:0] s_sum;
  logic signed [43:0] prod2_nxt;
  logic signed [43:0] rnd2;
  logic [25:0]        mag;
  logic               below;
  logic signed [26:0] delta;
  logic signed [26:0] step_s;
  logic signed [26:0] delta_c;
  logic signed [26:0] tgt_sum;
  logic signed [25:0] tgt_nxt;

  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign div_start = q_pop && (q_head.kind != kvcs_pkg::KIND_ZERO);

  always_comb begin
    negate    = (kind_r == kvcs_pkg::KIND_NEG) ^ cfg.invert;
    cmd_mag   = (kind_r == kvcs_pkg::KIND_ZERO) ? 18'd0 : {1'b0, div_quot};
    cmd_nxt   = negate ? -$signed(cmd_mag) : $signed(cmd_mag);
    diff      = $signed({cmd_r[17], cmd_r}) - $signed({s_r[17], s_r});
    prod1_nxt = diff * $signed({1'b0, cfg.alpha});
    rnd1      = prod1_r + 37'sd32768;
    s_sum     = $signed({{3{s_r[17]}}, s_r}) + $signed(rnd1[36:16]);
    prod2_nxt = s_r * $signed({1'b0, cfg.vmax});
    rnd2      = prod2_r + 44'sd32768;
    mag       = vel_r[25] ? 26'(-vel_r) : vel_r;
    below     = (mag < {1'b0, cfg.thresh});
    delta     = $signed({vel_r[25], vel_r}) - $signed({tgt_r[25], tgt_r});
    step_s    = $signed({2'b0, cfg.step});
    // clamp the target change to +/- step
    if (delta > step_s) begin
      delta_c = step_s;
    end else if (delta < -step_s) begin
      delta_c = -step_s;
    end else begin
      delta_c = delta;
    end
    tgt_sum = $signed({tgt_r[25], tgt_r}) + delta_c;
    tgt_nxt = below ? 26'sd0 : tgt_sum[25:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_head.kind == kvcs_pkg::KIND_ZERO) ? ST_CMD : ST_DIV;
        end
      end
      ST_DIV:  if (div_done) state_nxt = ST_CMD;
      ST_CMD:  state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_FILT;
      ST_FILT: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_VEL;
      ST_VEL:  state_nxt = ST_SLEW;
      ST_SLEW: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s_r         <= '0;
      seeded_r    <= 1'b0;
      tgt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_SLEW) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CMD: begin
          // seed the filter with the first command
          if (!seeded_r) begin
            s_r      <= cmd_nxt;
            seeded_r <= 1'b1;
          end
        end
        ST_FILT: s_r <= s_sum[17:0];
        ST_SLEW: begin
          if (out_free) begin
            tgt_r <= tgt_nxt;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r <= q_head.kind;
    end
    if (state_r == ST_CMD) begin
      cmd_r <= cmd_nxt;
    end
    if (state_r == ST_MUL1) begin
      prod1_r <= prod1_nxt;
    end
    if (state_r == ST_MUL2) begin
      prod2_r <= prod2_nxt;
    end
    if (state_r == ST_VEL) begin
      vel_r <= rnd2[41:16];
    end
    if ((state_r == ST_SLEW) && out_free) begin
      out_vel_r  <= tgt_nxt;
      out_en_r   <= !below;
      out_filt_r <= s_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_velocity = out_vel_r;
  assign out_enable   = out_en_r;
  assign out_filtered = out_filt_r;

endmodule

FILE: design/knob_velocity_command_shaper_unit.sv
`timescale 1ns / 1ps

// Knob velocity command shaper.
// in_*  : one raw 12-bit knob reading per item (stream slave).
// out_* : one result per item (stream master): slewed velocity target,
//         smoothed knob command, and drive enable in out_tuser.
// cfg_* : register writes, one per cycle with cfg_we high; take effect at once
//         and are meant to be written while no item is in flight.
// Front: the reading is normalized in the accept cycle, registered, then classified
// against the dead zone and pushed into a two-entry queue.
// Back: a 17-step restoring divider forms the command, then the filter and
// velocity multiplies and the slew step run as states in turn.
// Inside the dead zone the divider is skipped. The back end works on one item
// at a time; the front and the queue keep taking readings while it is busy.
// Reset (synchronous, rst_n low) restores the register defaults, clears the
// filter and target state and marks the filter unseeded.
// A stalled receiver holds the result in the output register; the back end
// waits there, the queue fills, and in_tready drops once the front is full.

module knob_velocity_command_shaper_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] knob_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [25:0] velocity_target, [43:26] filtered_command
  output logic        out_tuser,  // [0] drive_enable
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [24:0] cfg_wdata
);

  kvcs_pkg::cfg_t     cfg_r;
  kvcs_pkg::q_entry_t push_entry;
  kvcs_pkg::q_entry_t q_head;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_valid;
  logic [25:0]        out_velocity;
  logic [17:0]        out_filtered;
  logic [16:0]        wq16;
  logic [24:0]        wvel;

  // clamp fractions to 1.0 and velocities to full scale
  always_comb begin
    wq16 = (cfg_wdata[16:0] > 17'(kvcs_pkg::Q16_ONE)) ? 17'(kvcs_pkg::Q16_ONE)
                                                      : cfg_wdata[16:0];
    wvel = (cfg_wdata > 25'(kvcs_pkg::VEL_MAX)) ? 25'(kvcs_pkg::VEL_MAX) : cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center   <= 17'd32768;
      cfg_r.deadband <= 17'd1966;
      cfg_r.alpha    <= 17'd1311;
      cfg_r.vmax     <= 25'd16384000;
      cfg_r.thresh   <= 25'd65536;
      cfg_r.step     <= 25'd2621;
      cfg_r.invert   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        kvcs_pkg::REG_CENTER:   cfg_r.center   <= wq16;
        kvcs_pkg::REG_DEADBAND: cfg_r.deadband <= wq16;
        kvcs_pkg::REG_ALPHA:    cfg_r.alpha    <= wq16;
        kvcs_pkg::REG_VMAX:     cfg_r.vmax     <= wvel;
        kvcs_pkg::REG_THRESH:   cfg_r.thresh   <= wvel;
        kvcs_pkg::REG_STEP:     cfg_r.step     <= wvel;
        kvcs_pkg::REG_INVERT:   cfg_r.invert   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  kvcs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sample   (in_tdata[11:0]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  kvcs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  kvcs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_velocity (out_velocity),
    .out_enable   (out_tuser),
    .out_filtered (out_filtered)
  );

  assign out_tdata = {4'b0, out_filtered, out_velocity};

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("push into full queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[25:0] == 26'd0))
    else $error("disabled drive with nonzero target");

  a_filt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[43:26]) >= -18'sd65536 &&
                    $signed(out_tdata[43:26]) <= 18'sd65536))
    else $error("filtered command out of range");

endmodule

FILE: sim/kvcs_result_checker.sv
`timescale 1ns / 1ps

module kvcs_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        out_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [24:0] cfg_wdata,
  output int          fail_count,
  output int          pending_count,
  output int          result_count,
  output int          enabled_count
);

  localparam longint ONE      = 65536;
  localparam longint VEL_CAP  = 16777216;
  localparam longint HALF_LSB = 32768;
  localparam longint NORM_DIV = 4095;
  localparam longint NORM_RND = 2047;
  localparam int     MAX_PRINTED = 40;

  typedef struct {
    logic [25:0] target;
    logic        enable;
    logic [17:0] command;
  } shaper_result_t;

  shaper_result_t shaper_results_q[$];

  logic [16:0] center_r;
  logic [16:0] deadband_r;
  logic [16:0] alpha_r;
  logic [24:0] vmax_r;
  logic [24:0] thresh_r;
  logic [24:0] slew_r;
  logic        invert_r;

  longint smooth_cmd;
  longint slewed_target;
  bit     seeded;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    result_count  = 0;
    enabled_count = 0;
  end

  function automatic longint cap(input longint v, input longint hi);
    return (v > hi) ? hi : v;
  endfunction

  // Signed Q16 knob command after scaling, dead zone and direction.
  function automatic longint knob_command(input logic [11:0] reading);
    longint norm, c, d, upper, lower, cmd;
    norm = (longint'(reading) * ONE + NORM_RND) / NORM_DIV;
    if (norm > ONE) norm = ONE;
    c = cap(longint'(center_r), ONE);
    d = cap(longint'(deadband_r), ONE);
    upper = c + d;
    lower = c - d;
    cmd = 0;
    if (norm > upper) begin
      if (ONE - upper > 0) cmd = (norm - upper) * ONE / (ONE - upper);
    end else if (norm < lower) begin
      if (lower > 0) cmd = -((lower - norm) * ONE / lower);
    end
    if (invert_r) cmd = -cmd;
    return cmd;
  endfunction

  task automatic predict_velocity(input logic [11:0] reading);
    longint cmd, alpha, vmax, thresh, slew_lim, vel, mag, delta;
    shaper_result_t r;
    cmd      = knob_command(reading);
    alpha    = cap(longint'(alpha_r), ONE);
    vmax     = cap(longint'(vmax_r), VEL_CAP);
    thresh   = cap(longint'(thresh_r), VEL_CAP);
    slew_lim = cap(longint'(slew_r), VEL_CAP);
    // seed the filter with the first command after reset
    if (!seeded) begin
      smooth_cmd = cmd;
      seeded = 1'b1;
    end
    smooth_cmd = smooth_cmd + (((cmd - smooth_cmd) * alpha + HALF_LSB) >>> 16);
    vel = (smooth_cmd * vmax + HALF_LSB) >>> 16;
    mag = (vel < 0) ? -vel : vel;
    if (mag < thresh) begin
      slewed_target = 0;
      r.enable = 1'b0;
    end else begin
      delta = vel - slewed_target;
      if (delta > slew_lim) delta = slew_lim;
      if (delta < -slew_lim) delta = -slew_lim;
      slewed_target = slewed_target + delta;
      r.enable = 1'b1;
    end
    r.target  = slewed_target[25:0];
    r.command = smooth_cmd[17:0];
    shaper_results_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (fail_count < MAX_PRINTED)
      $display("[%0t] mismatch on %s at result %0d: got %0d, want %0d",
               $time, what, result_count, got, want);
    fail_count++;
  endtask

  task automatic check_result();
    shaper_result_t want;
    longint got_target, got_command;
    got_target  = longint'($signed(out_tdata[25:0]));
    got_command = longint'($signed(out_tdata[43:26]));
    if (shaper_results_q.size() == 0) begin
      report_mismatch("result with no pending item", got_target, 0);
      return;
    end
    want = shaper_results_q.pop_front();
    if (out_tdata[25:0] !== want.target)
      report_mismatch("velocity_target", got_target, longint'($signed(want.target)));
    if (out_tdata[43:26] !== want.command)
      report_mismatch("filtered_command", got_command, longint'($signed(want.command)));
    if (out_tuser !== want.enable)
      report_mismatch("drive_enable", longint'(out_tuser), longint'(want.enable));
    result_count++;
    if (want.enable) enabled_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      center_r      = 17'd32768;
      deadband_r    = 17'd1966;
      alpha_r       = 17'd1311;
      vmax_r        = 25'd16384000;
      thresh_r      = 25'd65536;
      slew_r        = 25'd2621;
      invert_r      = 1'b0;
      smooth_cmd    = 0;
      slewed_target = 0;
      seeded        = 1'b0;
      shaper_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          kvcs_pkg::REG_CENTER:   center_r   = cfg_wdata[16:0];
          kvcs_pkg::REG_DEADBAND: deadband_r = cfg_wdata[16:0];
          kvcs_pkg::REG_ALPHA:    alpha_r    = cfg_wdata[16:0];
          kvcs_pkg::REG_VMAX:     vmax_r     = cfg_wdata;
          kvcs_pkg::REG_THRESH:   thresh_r   = cfg_wdata;
          kvcs_pkg::REG_STEP:     slew_r     = cfg_wdata;
          kvcs_pkg::REG_INVERT:   invert_r   = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_velocity(in_tdata[11:0]);
      if (out_tvalid && out_tready) check_result();
    end
    pending_count <= shaper_results_q.size();
  end

endmodule

FILE: sim/tb_knob_velocity_command_shaper_unit.sv
`timescale 1ns / 1ps

module tb_knob_velocity_command_shaper_unit;

  localparam int RAND_PHASES    = 10;
  localparam int PHASE_ITEMS    = 112;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = kvcs_pkg::REG_CENTER;
  logic [24:0] cfg_wdata = '0;

  int fail_count, pending_count, result_count, enabled_count;
  int items_sent = 0;
  int settings_loaded = 0;
  int idle_cycles = 0;
  int send_gap_pct = 30;
  int sink_stall_pct = 30;
  bit quiet = 1'b0;
  int sweep_pos = 2048;
  int sweep_rate = 37;
  logic [11:0] last_knob = '0;

  always #6 clk = ~clk;

  knob_velocity_command_shaper_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  kvcs_result_checker result_watch (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count),
    .enabled_count (enabled_count)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: stall in random bursts, never once quiet.
  initial begin : sink_ctl
    @(posedge clk);
    forever begin
      if (!quiet && ($urandom_range(0, 99) < sink_stall_pct)) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  task automatic send_knob(input logic [11:0] reading);
    in_tdata  <= {4'd0, reading};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    last_knob = reading;
    if (!quiet && ($urandom_range(0, 99) < send_gap_pct)) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Hold the input until every pending result is out.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [24:0] value);
    cfg_idx   <= idx;
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [24:0] center, deadband, alpha,
                               input logic [24:0] vmax, thresh, slew_lim,
                               input logic [24:0] invert);
    write_reg(kvcs_pkg::REG_CENTER, center);
    write_reg(kvcs_pkg::REG_DEADBAND, deadband);
    write_reg(kvcs_pkg::REG_ALPHA, alpha);
    write_reg(kvcs_pkg::REG_VMAX, vmax);
    write_reg(kvcs_pkg::REG_THRESH, thresh);
    write_reg(kvcs_pkg::REG_STEP, slew_lim);
    write_reg(kvcs_pkg::REG_INVERT, invert);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // Mostly typical values, sometimes zero, the top of range or any raw value.
  function automatic logic [24:0] pick_reg(input int unsigned limit, lo, hi, mask);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 25'(limit);
      2:       return 25'($urandom & mask);
      default: return 25'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic next_knob(output logic [11:0] reading);
    case ($urandom_range(0, 9))
      0, 1, 2: reading = 12'($urandom_range(0, 4095));
      3, 4, 5: begin
        sweep_pos = sweep_pos + sweep_rate;
        if (sweep_pos > 4095) begin
          sweep_pos = 4095;
          sweep_rate = -sweep_rate;
        end
        if (sweep_pos < 0) begin
          sweep_pos = 0;
          sweep_rate = -sweep_rate;
        end
        reading = 12'(sweep_pos);
      end
      6, 7:    reading = 12'(1748 + $urandom_range(0, 600));
      8:       reading = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
      default: reading = last_knob;
    endcase
  endtask

  initial begin : stimulus
    logic [11:0] reading;
    int hold_at;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: seed at full deflection, then dead-zone edges
    send_knob(12'd4095); send_knob(12'd4095); send_knob(12'd0); send_knob(12'd2048);
    send_knob(12'd2169); send_knob(12'd2171); send_knob(12'd1924); send_knob(12'd1925);

    // instant filter, full scale, inverted, no threshold
    settle();
    load_settings(25'd32768, 25'd0, 25'd65536, 25'd16777216, 25'd0, 25'd16777216, 25'd1);
    send_knob(12'd0); send_knob(12'd4095); send_knob(12'd2048); send_knob(12'd4095);
    send_knob(12'd0);

    // registers above range; positive side has no span
    settle();
    load_settings(25'h1FFFF, 25'd0, 25'h1FFFF, 25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF, 25'd0);
    send_knob(12'd0); send_knob(12'd4095); send_knob(12'd0); send_knob(12'd2048);

    // center at zero: negative side has no span
    settle();
    load_settings(25'd0, 25'd0, 25'd65536, 25'd16777216, 25'd16777216, 25'd1000, 25'd0);
    send_knob(12'd0); send_knob(12'd4095); send_knob(12'd4095); send_knob(12'd1);

    // one-LSB divisor, zero slew step
    settle();
    load_settings(25'd65535, 25'd0, 25'd32768, 25'd1000000, 25'd65536, 25'd0, 25'd0);
    send_knob(12'd4095); send_knob(12'd4095); send_knob(12'd0);

    // dead zone covers everything, frozen filter
    settle();
    load_settings(25'd40000, 25'h1FFFF, 25'd0, 25'd8000000, 25'd100, 25'd5000, 25'd0);
    send_knob(12'd4095); send_knob(12'd0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      quiet = (p == RAND_PHASES - 1);
      case ($urandom_range(0, 2))
        0:       send_gap_pct = 0;
        1:       send_gap_pct = 15;
        default: send_gap_pct = 45;
      endcase
      case ($urandom_range(0, 2))
        0:       sink_stall_pct = 0;
        1:       sink_stall_pct = 20;
        default: sink_stall_pct = 50;
      endcase
      load_settings(pick_reg(65536, 16384, 49152, 32'h1FFFF),
                    pick_reg(65536, 0, 8000, 32'h1FFFF),
                    pick_reg(65536, 500, 65536, 32'h1FFFF),
                    pick_reg(16777216, 65536, 16777216, 32'h1FFFFFF),
                    pick_reg(16777216, 0, 2000000, 32'h1FFFFFF),
                    pick_reg(16777216, 500, 600000, 32'h1FFFFFF),
                    pick_reg(1, 0, 1, 32'h1));
      sweep_rate = $urandom_range(0, 1) ? $urandom_range(5, 200) : -$urandom_range(5, 200);
      hold_at = $urandom_range(10, PHASE_ITEMS - 10);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == hold_at) settle();
        next_knob(reading);
        send_knob(reading);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Drove %0d knob readings under %0d register settings (directed extremes,",
             items_sent, settings_loaded + 1);
    $display("dead-zone edges, sweeps and random holds); %0d results compared, %0d driving.",
             result_count, enabled_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
